// File: rtl/nimmul_pkg.sv
// Shared sizes and types for the 32-bit nimber multiplier.
package nimmul_pkg;

	localparam int unsigned FIELD_W = 32;
	// Three half-width products per level over five levels: 3**5 one-bit leaves
	localparam int unsigned LEAF_N  = 243;

	typedef logic [FIELD_W-1:0] word_t;
	typedef logic [LEAF_N-1:0]  leaf_t;

endpackage

// File: rtl/nimmul_split.sv
// Operand expansion: splits a 32-bit nimber into the 243 leaf bits of the product tree.
module nimmul_split import nimmul_pkg::*; (
	input  word_t operand,
	output leaf_t leaf
);

	logic [2:0][15:0] op16;
	logic [8:0][7:0]  op8;
	logic [26:0][3:0] op4;
	logic [80:0][1:0] op2;

	// Each node feeds three children: high half, low half, and their xor
	always_comb begin
		op16[0] = operand[31:16];
		op16[1] = operand[15:0];
		op16[2] = operand[31:16] ^ operand[15:0];

		for (int g = 0; g < 3; g++) begin
			op8[3*g]   = op16[g][15:8];
			op8[3*g+1] = op16[g][7:0];
			op8[3*g+2] = op16[g][15:8] ^ op16[g][7:0];
		end

		for (int g = 0; g < 9; g++) begin
			op4[3*g]   = op8[g][7:4];
			op4[3*g+1] = op8[g][3:0];
			op4[3*g+2] = op8[g][7:4] ^ op8[g][3:0];
		end

		for (int g = 0; g < 27; g++) begin
			op2[3*g]   = op4[g][3:2];
			op2[3*g+1] = op4[g][1:0];
			op2[3*g+2] = op4[g][3:2] ^ op4[g][1:0];
		end

		for (int g = 0; g < 81; g++) begin
			leaf[3*g]   = op2[g][1];
			leaf[3*g+1] = op2[g][0];
			leaf[3*g+2] = op2[g][1] ^ op2[g][0];
		end
	end

endmodule

// File: rtl/nimber_multiplier_32bit_unit.sv
// Top level of the pipelined 32-bit nimber multiplier.
// Throughput: one operand pair per cycle; busy is held low, start may stay high.
// Each result sits on nim_product for exactly one cycle with done high.
// Reset (arst_n low, asynchronous) drops every valid bit; payload flops are not reset.
// Pipeline: s1 leaf bits, s2 4-bit products, s3 16-bit products, s4 full product.
module nimber_multiplier_32bit_unit import nimmul_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  word_t lhs_operand,
	input  word_t rhs_operand,
	output word_t nim_product,
	output logic  done
);

	// Multiply by the half-Fermat element 2**(w-1) inside a w-bit subfield.
	// With x = c*T + d: high = S'(c^d), low = S'(S'(c)), S' one level down.
	function automatic logic [1:0] scl1(input logic [1:0] h);
		return {h[1] ^ h[0], h[1]};
	endfunction

	function automatic logic [3:0] scl2(input logic [3:0] h);
		logic [1:0] c;
		logic [1:0] d;
		c = h[3:2];
		d = h[1:0];
		return {scl1(c ^ d), scl1(scl1(c))};
	endfunction

	function automatic logic [7:0] scl3(input logic [7:0] h);
		logic [3:0] c;
		logic [3:0] d;
		c = h[7:4];
		d = h[3:0];
		return {scl2(c ^ d), scl2(scl2(c))};
	endfunction

	function automatic logic [15:0] scl4(input logic [15:0] h);
		logic [7:0] c;
		logic [7:0] d;
		c = h[15:8];
		d = h[7:0];
		return {scl3(c ^ d), scl3(scl3(c))};
	endfunction

	leaf_t lhs_leaf;
	leaf_t rhs_leaf;

	leaf_t lx_s1;
	leaf_t ly_s1;
	logic  vld_s1;

	logic [26:0][3:0] p2_s2;
	logic             vld_s2;

	logic [2:0][15:0] p4_s3;
	logic             vld_s3;

	// Stage 1 operand trees
	nimmul_split u_split_lhs (
		.operand (lhs_operand),
		.leaf    (lhs_leaf)
	);

	nimmul_split u_split_rhs (
		.operand (rhs_operand),
		.leaf    (rhs_leaf)
	);

	// Nothing downstream can stall, so a beat is taken every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	// Hold the leaf bits; payload advances with the valid bit
	always_ff @(posedge clk) begin
		lx_s1 <= lhs_leaf;
		ly_s1 <= rhs_leaf;
	end

	// Stage 2: leaf ANDs, then fold up to 4-bit products.
	// Children of a node come as (high product, low product, cross product):
	// result high = cross ^ low, result low = scale(high) ^ low.
	logic [LEAF_N-1:0] p0;
	logic [80:0][1:0]  p1;
	logic [26:0][3:0]  p2;

	always_comb begin
		p0 = lx_s1 & ly_s1;
		for (int g = 0; g < 81; g++) begin
			p1[g] = {p0[3*g+2] ^ p0[3*g+1], p0[3*g] ^ p0[3*g+1]};
		end
		for (int g = 0; g < 27; g++) begin
			p2[g] = {p1[3*g+2] ^ p1[3*g+1], scl1(p1[3*g]) ^ p1[3*g+1]};
		end
	end

	always_ff @(posedge clk) begin
		p2_s2 <= p2;
	end

	// Stage 3: fold 4-bit products into 8-bit, then 16-bit
	logic [8:0][7:0]  p3;
	logic [2:0][15:0] p4;

	always_comb begin
		for (int g = 0; g < 9; g++) begin
			p3[g] = {p2_s2[3*g+2] ^ p2_s2[3*g+1], scl2(p2_s2[3*g]) ^ p2_s2[3*g+1]};
		end
		for (int g = 0; g < 3; g++) begin
			p4[g] = {p3[3*g+2] ^ p3[3*g+1], scl3(p3[3*g]) ^ p3[3*g+1]};
		end
	end

	always_ff @(posedge clk) begin
		p4_s3 <= p4;
	end

	// Stage 4: last Karatsuba fold into the output register
	always_ff @(posedge clk) begin
		nim_product <= {p4_s3[2] ^ p4_s3[1], scl4(p4_s3[0]) ^ p4_s3[1]};
	end

endmodule
